>>> sv/epsq_pkg.sv
// ----------------------------------------------------------------------------
// epsq_pkg
// Shared types, field widths and default sizes of the publish/subscribe
// event queue.
// ----------------------------------------------------------------------------
package epsq_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int NUM_CONTROLS_DEF = 32;
  localparam int NUM_MODULES_DEF  = 16;
  localparam int VALUE_BITS_DEF   = 32;

  // fixed field widths on the stream ports
  localparam int OP_W      = 2;
  localparam int MOD_W     = 4;
  localparam int CTRL_W    = 5;
  localparam int DATA_W    = 32;
  localparam int MASK_W    = 16;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 56;

  typedef enum logic [OP_W-1:0] {
    OP_SUBSCRIBE = 2'd0,
    OP_PUBLISH   = 2'd1,
    OP_DISPATCH  = 2'd2
  } op_e;

endpackage

>>> sv/epsq_ram.sv
// ----------------------------------------------------------------------------
// epsq_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module epsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/event_publish_subscribe_queue.sv
// ----------------------------------------------------------------------------
// event_publish_subscribe_queue
// Event dispatcher: subscribe items set module bits in per-control masks,
// publish items push events into a ring fifo or drop them when it is full,
// dispatch items pop the oldest event and return it with the mask of its control.
// ----------------------------------------------------------------------------
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tuser: op, tdata: module, control, value
// m_axis   out  m_axis_tvalid/m_axis_tready  tuser: dispatched, tdata: result fields
//
// one item per cycle sustained while the output is not stalled; a result passes
// the queue ram read, then the subscriber mask ram read, before it is registered out
// after reset the mask rams are zeroed, every control in turn, with
// s_axis_tready low
// a stalled output holds one result and one more item in flight, then
// s_axis_tready drops
// ----------------------------------------------------------------------------
module event_publish_subscribe_queue
  import epsq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int NUM_CONTROLS = NUM_CONTROLS_DEF,
  parameter int NUM_MODULES  = NUM_MODULES_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // module_req [3:0], control [8:4], value [40:9], zero [47:41]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // op [1:0]
  input  logic [OP_W-1:0]      s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_control [4:0], out_value [36:5], subscriber_mask [52:37],
  // dropped [53], queue_full [54], zero [55]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // dispatched [0]
  output logic                 m_axis_tuser
);

  localparam int QA  = $clog2(QUEUE_DEPTH);
  localparam int CA  = $clog2(NUM_CONTROLS);
  localparam int NMB = NUM_MODULES - 1;
  localparam int VW  = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
  localparam int QW  = CTRL_W + VW;

  function automatic logic [QA-1:0] ptr_next(input logic [QA-1:0] p);
    if (p == QA'(QUEUE_DEPTH - 1)) begin
      return '0;
    end else begin
      return p + 1'b1;
    end
  endfunction

  // input fields
  op_e               in_op;
  logic [MOD_W-1:0]  in_module;
  logic [CTRL_W-1:0] in_control;
  logic [DATA_W-1:0] in_value;

  assign in_op      = op_e'(s_axis_tuser);
  assign in_module  = s_axis_tdata[3:0];
  assign in_control = s_axis_tdata[8:4];
  assign in_value   = s_axis_tdata[40:9];

  // queue state
  logic [QA-1:0] rd_q, rd_d, wr_q, wr_d;
  logic          full_q, full_d;

  // mask clearing after reset
  logic          clr_q;
  logic [CA-1:0] clr_cnt_q;

  // pipeline
  logic          s1_valid_q, s1_disp_q, s1_drop_q, s1_full_q;
  logic          m_valid_q, s2_disp_q, s2_inr_q, s2_drop_q, s2_full_q;
  logic [CTRL_W-1:0] s2_ctl_q;
  logic [VW-1:0]     s2_val_q;

  logic accept, adv2, ld1;
  logic sub_ok, push_ok, drop_now, pop_ok;
  logic [QW-1:0]     q_rdata;
  logic [CTRL_W-1:0] s1_ctl;
  logic [VW-1:0]     s1_val;
  logic [NMB-1:0]    mask_bits;

  assign adv2          = !m_valid_q || m_axis_tready;
  assign ld1           = !s1_valid_q || adv2;
  assign s_axis_tready = ld1 && !clr_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    sub_ok   = 1'b0;
    push_ok  = 1'b0;
    drop_now = 1'b0;
    pop_ok   = 1'b0;
    case (in_op)
      OP_SUBSCRIBE: begin
        sub_ok = (in_control != '0) && (32'(in_control) < NUM_CONTROLS) &&
                 (in_module != '0) && (32'(in_module) < NUM_MODULES);
      end
      OP_PUBLISH: begin
        push_ok  = (in_control != '0) && !full_q;
        drop_now = (in_control != '0) && full_q;
      end
      OP_DISPATCH: begin
        pop_ok = full_q || (rd_q != wr_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_d   = rd_q;
    wr_d   = wr_q;
    full_d = full_q;
    if (push_ok) begin
      wr_d   = ptr_next(wr_q);
      full_d = (ptr_next(wr_q) == rd_q);
    end else if (pop_ok) begin
      rd_d   = ptr_next(rd_q);
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      wr_q   <= '0;
      full_q <= 1'b0;
    end else if (accept) begin
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == CA'(NUM_CONTROLS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // event storage: control in the low bits, value above
  epsq_ram #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (accept && push_ok),
    .waddr_i(wr_q),
    .wdata_i({in_value[VW-1:0], in_control}),
    .re_i   (accept && pop_ok),
    .raddr_i(rd_q),
    .rdata_o(q_rdata)
  );

  assign s1_ctl = q_rdata[CTRL_W-1:0];
  assign s1_val = q_rdata[QW-1:CTRL_W];

  // one single-bit ram per module 1 to NUM_MODULES-1, addressed by control code
  for (genvar b = 0; b < NMB; b++) begin : g_mask
    logic          we_b;
    logic [CA-1:0] waddr_b;

    assign we_b    = clr_q || (accept && sub_ok && (32'(in_module) == b + 1));
    assign waddr_b = clr_q ? clr_cnt_q : CA'(in_control);

    epsq_ram #(
      .WIDTH(1),
      .DEPTH(NUM_CONTROLS)
    ) u_mask_ram (
      .clk_i  (clk_i),
      .we_i   (we_b),
      .waddr_i(waddr_b),
      .wdata_i(!clr_q),
      .re_i   (adv2),
      .raddr_i(CA'(s1_ctl)),
      .rdata_o(mask_bits[b])
    );
  end

  // stage 1: queue read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ld1) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_disp_q <= pop_ok;
      s1_drop_q <= drop_now;
      s1_full_q <= full_d;
    end
  end

  // stage 2: result register, mask ram data lands alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv2) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_disp_q <= s1_disp_q;
      s2_ctl_q  <= s1_ctl;
      s2_val_q  <= s1_val;
      s2_inr_q  <= (32'(s1_ctl) < NUM_CONTROLS);
      s2_drop_q <= s1_drop_q;
      s2_full_q <= s1_full_q;
    end
  end

  logic [CTRL_W-1:0] out_ctl;
  logic [DATA_W-1:0] out_val;
  logic [63:0]       mask_ext;
  logic [MASK_W-1:0] out_mask;

  assign out_ctl  = s2_disp_q ? s2_ctl_q : '0;
  assign out_val  = s2_disp_q ? DATA_W'(s2_val_q) : '0;
  assign mask_ext = 64'(mask_bits);
  assign out_mask = (s2_disp_q && s2_inr_q) ? mask_ext[MASK_W-1:0] : '0;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = s2_disp_q;
  assign m_axis_tdata  = {1'b0, s2_full_q, s2_drop_q, out_mask, out_val, out_ctl};

`ifndef NO_ASSERTIONS
  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (rd_q == wr_q))
    else $error("queue full with pointers apart");

  a_clr_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready)
    else $error("item taken while masks are cleared");

  a_pop_clears_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && pop_ok) |=> !full_q)
    else $error("queue still full after a pop");

  a_disp_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(s2_disp_q && s2_drop_q))
    else $error("result both dispatched and dropped");

  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && adv2) |=> m_valid_q)
    else $error("item lost between stages");
`endif

endmodule
